// File: rtl/core/pbcr_pkg.sv
package pbcr_pkg;

    typedef enum logic [2:0] {
        REQ_READ     = 3'd0,
        REQ_UNPIN    = 3'd1,
        REQ_DIRTY    = 3'd2,
        REQ_ALLOC    = 3'd3,
        REQ_CLOSE    = 3'd4,
        REQ_RSVD5    = 3'd5,
        REQ_RSVD6    = 3'd6,
        REQ_RSVD7    = 3'd7
    } req_code_t;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_INSTALLED  = 3'd1,
        ST_HEADER     = 3'd2,
        ST_ALL_PINNED = 3'd3,
        ST_NOT_RES    = 3'd4,
        ST_WRITEBACK  = 3'd5,
        ST_CLOSE_DONE = 3'd6
    } status_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOOK_RD,
        S_LOOK_EV,
        S_HAND_MOD,
        S_SWP_RD,
        S_SWP_EV,
        S_CLS_RD,
        S_CLS_EV,
        S_RESP
    } eng_state_t;

    localparam logic [0:0] REG_FRAMES_IN_USE   = 1'b0;
    localparam logic [4:0] FRAMES_IN_USE_RESET = 5'd16;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  tid;
        logic [31:0] pg_no;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame_index;
        logic        wb_valid;
        logic [3:0]  wb_table;
        logic [31:0] wb_page;
        logic        load_needed;
        logic        last;
    } rsp_t;

endpackage

// File: rtl/core/pbcr_out_reg.sv
module pbcr_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  pbcr_pkg::rsp_t data,
    output logic          free,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pbcr_pkg::rsp_t rsp
);
    import pbcr_pkg::*;

    logic valid_reg;
    rsp_t data_reg;

    assign free      = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= data;
        end
    end

endmodule

// File: rtl/core/pbcr_engine.sv
module pbcr_engine #(
    parameter int FRAMES     = 16,
    parameter int MAX_TABLES = 16,
    parameter int PIN_BITS   = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [4:0]     frames_in_use,
    input  logic           req_valid,
    output logic           req_stall,
    input  pbcr_pkg::req_t req,
    input  logic           out_free,
    output logic           out_load,
    output pbcr_pkg::rsp_t out_data
);
    import pbcr_pkg::*;

    localparam int FIDX = $clog2(FRAMES);
    localparam int CNTW = $clog2(FRAMES + 1);
    localparam int CW   = $clog2(2 * FRAMES + 2);

    typedef struct packed {
        logic                dirty;
        logic                refd;
        logic [PIN_BITS-1:0] pins;
        logic [3:0]          tbl;
        logic [31:0]         page;
    } entry_t;

    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    entry_t mem [FRAMES];
    entry_t rd_reg;
    logic   mem_re;
    logic   mem_we;
    logic [FIDX-1:0] mem_raddr;
    logic [FIDX-1:0] mem_waddr;
    entry_t mem_wdata;

    eng_state_t state_reg, state_next;
    req_t    rq_reg, rq_next;
    rsp_t    pend_reg, pend_next;
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [FIDX-1:0] idx_reg, idx_next;
    logic [FIDX-1:0] hand_reg, hand_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    logic [CNTW-1:0] n_act;
    logic [CNTW-1:0] idx_p1;
    logic [CNTW-1:0] hand_p1;
    logic [FIDX-1:0] hand_adv;
    logic            idx_end;
    logic            match_tp;
    logic            tid_bad;
    logic            pinned;

    always_comb
    begin
        if (frames_in_use == 5'd0)
        begin
            n_act = CNTW'(1);
        end
        else if (32'(frames_in_use) > FRAMES)
        begin
            n_act = CNTW'(FRAMES);
        end
        else
        begin
            n_act = CNTW'(frames_in_use);
        end
    end

    assign idx_p1   = CNTW'(idx_reg) + CNTW'(1);
    assign idx_end  = (idx_p1 == n_act);
    assign hand_p1  = CNTW'(hand_reg) + CNTW'(1);
    assign hand_adv = (hand_p1 == n_act) ? '0 : FIDX'(hand_p1);
    assign match_tp = valid_reg[idx_reg] && (rd_reg.tbl == rq_reg.tid)
                      && (rd_reg.page == rq_reg.pg_no);
    assign tid_bad  = 32'(rq_reg.tid) >= MAX_TABLES;
    assign pinned   = (rq_reg.req_type == REQ_READ);

    assign req_stall = (state_reg != S_IDLE);
    assign out_load  = (state_reg == S_RESP);
    assign out_data  = pend_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (rq_reg.req_type > REQ_CLOSE)
                begin
                    state_next = S_IDLE;
                end
                else if (tid_bad || (rq_reg.req_type != REQ_CLOSE
                                     && rq_reg.pg_no == 32'd0))
                begin
                    state_next = S_RESP;
                end
                else if (rq_reg.req_type == REQ_CLOSE)
                begin
                    state_next = S_CLS_RD;
                end
                else
                begin
                    state_next = S_LOOK_RD;
                end
            end
            S_LOOK_RD:
            begin
                state_next = S_LOOK_EV;
            end
            S_LOOK_EV:
            begin
                if (match_tp)
                begin
                    state_next = S_RESP;
                end
                else if (!idx_end)
                begin
                    state_next = S_LOOK_RD;
                end
                else if (rq_reg.req_type == REQ_READ || rq_reg.req_type == REQ_ALLOC)
                begin
                    state_next = S_HAND_MOD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_HAND_MOD:
            begin
                if (CNTW'(hand_reg) < n_act)
                begin
                    state_next = S_SWP_RD;
                end
            end
            S_SWP_RD:
            begin
                if (cnt_reg > CW'({n_act, 1'b0}))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SWP_EV;
                end
            end
            S_SWP_EV:
            begin
                if (!valid_reg[hand_reg] || (rd_reg.pins == '0 && !rd_reg.refd))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SWP_RD;
                end
            end
            S_CLS_RD:
            begin
                state_next = S_CLS_EV;
            end
            S_CLS_EV:
            begin
                if ((match_tp || (valid_reg[idx_reg] && rd_reg.tbl == rq_reg.tid
                                  && 1'b1)) && rd_reg.dirty)
                begin
                    state_next = S_RESP;
                end
                else if (idx_end)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_CLS_RD;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    if (pend_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!idx_end)
                    begin
                        state_next = S_CLS_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rq_next    = rq_reg;
        pend_next  = pend_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        hand_next  = hand_reg;
        cnt_next   = cnt_reg;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = rd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    rq_next = req;
                end
            end
            S_DISPATCH:
            begin
                pend_next      = '0;
                pend_next.last = 1'b1;
                idx_next       = '0;
                if (tid_bad)
                begin
                    pend_next.status = ST_NOT_RES;
                end
                else if (rq_reg.pg_no == 32'd0)
                begin
                    pend_next.status = ST_HEADER;
                end
            end
            S_LOOK_RD, S_CLS_RD:
            begin
                mem_re = 1'b1;
            end
            S_LOOK_EV:
            begin
                if (match_tp)
                begin
                    mem_we = 1'b1;
                    case (rq_reg.req_type)
                        REQ_READ:
                        begin
                            mem_wdata.refd = 1'b1;
                            if (rd_reg.pins != PIN_MAX)
                            begin
                                mem_wdata.pins = rd_reg.pins + PIN_BITS'(1);
                            end
                        end
                        REQ_UNPIN:
                        begin
                            if (rd_reg.pins != '0)
                            begin
                                mem_wdata.pins = rd_reg.pins - PIN_BITS'(1);
                            end
                        end
                        REQ_DIRTY:
                        begin
                            mem_wdata.dirty = 1'b1;
                        end
                        default:
                        begin
                            mem_wdata = rd_reg;
                        end
                    endcase
                    pend_next.status      = ST_HIT;
                    pend_next.frame_index = 4'(idx_reg);
                end
                else if (!idx_end)
                begin
                    idx_next = idx_reg + FIDX'(1);
                end
                else
                begin
                    pend_next.status = ST_NOT_RES;
                    cnt_next         = '0;
                end
            end
            S_HAND_MOD:
            begin
                if (CNTW'(hand_reg) >= n_act)
                begin
                    hand_next = FIDX'(CNTW'(hand_reg) - n_act);
                end
            end
            S_SWP_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = hand_reg;
                pend_next.status = ST_ALL_PINNED;
            end
            S_SWP_EV:
            begin
                mem_waddr = hand_reg;
                hand_next = hand_adv;
                if (!valid_reg[hand_reg] || (rd_reg.pins == '0 && !rd_reg.refd))
                begin
                    mem_we          = 1'b1;
                    mem_wdata.dirty = 1'b0;
                    mem_wdata.refd  = 1'b1;
                    mem_wdata.pins  = pinned ? PIN_BITS'(1) : '0;
                    mem_wdata.tbl   = rq_reg.tid;
                    mem_wdata.page  = rq_reg.pg_no;
                    valid_next[hand_reg]  = 1'b1;
                    pend_next.status      = ST_INSTALLED;
                    pend_next.frame_index = 4'(hand_reg);
                    pend_next.load_needed = pinned;
                    if (valid_reg[hand_reg] && rd_reg.dirty)
                    begin
                        pend_next.wb_valid = 1'b1;
                        pend_next.wb_table = rd_reg.tbl;
                        pend_next.wb_page  = rd_reg.page;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                    if (rd_reg.pins == '0)
                    begin
                        mem_we         = 1'b1;
                        mem_wdata.refd = 1'b0;
                    end
                end
            end
            S_CLS_EV:
            begin
                if (valid_reg[idx_reg] && rd_reg.tbl == rq_reg.tid)
                begin
                    valid_next[idx_reg] = 1'b0;
                end
                if (valid_reg[idx_reg] && rd_reg.tbl == rq_reg.tid && rd_reg.dirty)
                begin
                    pend_next.status      = ST_WRITEBACK;
                    pend_next.frame_index = 4'(idx_reg);
                    pend_next.wb_valid    = 1'b1;
                    pend_next.wb_table    = rd_reg.tbl;
                    pend_next.wb_page     = rd_reg.page;
                    pend_next.last        = 1'b0;
                end
                else if (idx_end)
                begin
                    pend_next        = '0;
                    pend_next.status = ST_CLOSE_DONE;
                    pend_next.last   = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + FIDX'(1);
                end
            end
            S_RESP:
            begin
                if (out_free && !pend_reg.last)
                begin
                    if (idx_end)
                    begin
                        pend_next        = '0;
                        pend_next.status = ST_CLOSE_DONE;
                        pend_next.last   = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + FIDX'(1);
                    end
                end
            end
            default:
            begin
                rq_next = rq_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            hand_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            hand_reg  <= hand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_reg   <= rq_next;
        pend_reg <= pend_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

endmodule

// File: rtl/core/page_buffer_clock_replacement_unit.sv
// Frame table of a page buffer pool with clock replacement. One request beat
// is taken at a time; the block stalls its request side until the last result
// of that request has been handed to the output register. The frame entries sit
// in one single-port-read memory and are visited one frame at a time, each in
// a read step and then an evaluate and write back step. A hit on frame k ends
// the lookup there. A miss on a read or alloc makes a full lookup pass over
// the n frames in use, brings the hand into range by subtracting n while it
// lies beyond them, and sweeps over at most 2*n+1 frames before it reports
// that every frame is pinned. A table close visits all n frames and gives one
// writeback result per dirty frame of that table and a final close-done result.
// A stall on the result side holds the block while a result is ready.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed.
module page_buffer_clock_replacement_unit #(
    parameter int FRAMES     = 16,
    parameter int MAX_TABLES = 16,
    parameter int PIN_BITS   = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    input  logic           req_valid,
    output logic           req_stall,
    input  pbcr_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output pbcr_pkg::rsp_t rsp
);
    import pbcr_pkg::*;

    logic [4:0] fiu_reg;
    logic       out_free;
    logic       out_load;
    rsp_t       out_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? {27'd0, fiu_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg <= FRAMES_IN_USE_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_FRAMES_IN_USE)
        begin
            fiu_reg <= pwdata[4:0];
        end
    end

    pbcr_engine #(
        .FRAMES     (FRAMES),
        .MAX_TABLES (MAX_TABLES),
        .PIN_BITS   (PIN_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .frames_in_use (fiu_reg),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .out_free      (out_free),
        .out_load      (out_load),
        .out_data      (out_data)
    );

    pbcr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .data      (out_data),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
